[src/nrp_pkg.sv]
// nrp_pkg: shared types, register indexes and datapath command codes
// for the nearest record picker. No dependencies.
package nrp_pkg;

	localparam int INDEX_WIDTH = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int OP_W        = 4;

	localparam logic [1:0] FUNC_POINT  = 2'd0;
	localparam logic [1:0] FUNC_CANDLE = 2'd1;
	localparam logic [1:0] FUNC_RECT   = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd4;

	localparam logic [31:0] SCALE_RESET = 32'd65536;
	localparam logic [31:0] MAXD_RESET  = 32'd655360;

	localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
	localparam logic [OP_W-1:0] OP_DELTA = 4'd2;
	localparam logic [OP_W-1:0] OP_MX    = 4'd3;
	localparam logic [OP_W-1:0] OP_MY    = 4'd4;
	localparam logic [OP_W-1:0] OP_SQX   = 4'd5;
	localparam logic [OP_W-1:0] OP_SQY   = 4'd6;
	localparam logic [OP_W-1:0] OP_MD    = 4'd7;
	localparam logic [OP_W-1:0] OP_CMP   = 4'd8;
	localparam logic [OP_W-1:0] OP_SQI   = 4'd9;
	localparam logic [OP_W-1:0] OP_SQS   = 4'd10;
	localparam logic [OP_W-1:0] OP_EMIT  = 4'd11;

	typedef struct packed {
		logic [1:0]             func;
		logic [31:0]            item_id;
		logic [INDEX_WIDTH-1:0] record_index;
		logic signed [31:0]     v0;
		logic signed [31:0]     v1;
		logic signed [31:0]     v2;
		logic signed [31:0]     v3;
		logic signed [31:0]     v4;
		logic signed [31:0]     v5;
		logic                   last;
	} rec_t;

	typedef struct packed {
		logic                   hit;
		logic [31:0]            best_item;
		logic [INDEX_WIDTH-1:0] best_index;
		logic signed [31:0]     data_x;
		logic signed [31:0]     data_y;
		logic [31:0]            distance;
	} res_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic last_rec;
	} dp_sts_t;

endpackage

[src/nrp_datapath.sv]
// nrp_datapath: config registers, distance arithmetic on one shared
// 32x32 multiplier, best-record tracking and a bit-pair square root.
// Depends on nrp_pkg.
module nrp_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  nrp_pkg::rec_t                 rec,
	input  nrp_pkg::dp_cmd_t              cmd,
	output nrp_pkg::dp_sts_t              sts,
	output nrp_pkg::res_t                 res
);

	logic signed [31:0] cx_q, cy_q;
	logic [31:0] sx_q, sy_q, md_q;

	nrp_pkg::rec_t rec_q;
	logic [31:0] mx_q, my_q, px_q, py_q;
	logic signed [31:0] ax_q, ay_q;
	logic valid_q;
	logic [63:0] prod_q, sqx_q, sq_q;

	logic have_q;
	logic [63:0] best_sq_q;
	logic [31:0] best_item_q;
	logic [nrp_pkg::INDEX_WIDTH-1:0] best_index_q;
	logic signed [31:0] best_x_q, best_y_q;

	logic [63:0] n_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	nrp_pkg::res_t res_q;

	function automatic logic [31:0] mag33(input logic [32:0] d);
		logic [32:0] a;
		a = d[32] ? (33'd0 - d) : d;
		return a[31:0];
	endfunction

	function automatic logic [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
		return {a[31], a} - {b[31], b};
	endfunction

	function automatic logic [31:0] half33(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		return s[32:1];
	endfunction

	logic [31:0] mx_c, my_c, dl_c, dh_c;
	logic signed [31:0] ax_c, ay_c, lx_c, hx_c, ly_c, hy_c, clx_c, cly_c;
	logic valid_c;

	always_comb begin
		mx_c    = '0;
		my_c    = '0;
		ax_c    = '0;
		ay_c    = '0;
		valid_c = 1'b1;
		dl_c    = mag33(sub33(cy_q, rec_q.v3));
		dh_c    = mag33(sub33(cy_q, rec_q.v2));
		lx_c    = (rec_q.v0 < rec_q.v2) ? rec_q.v0 : rec_q.v2;
		hx_c    = (rec_q.v0 < rec_q.v2) ? rec_q.v2 : rec_q.v0;
		ly_c    = (rec_q.v1 < rec_q.v3) ? rec_q.v1 : rec_q.v3;
		hy_c    = (rec_q.v1 < rec_q.v3) ? rec_q.v3 : rec_q.v1;
		clx_c   = (cx_q < lx_c) ? lx_c : ((cx_q > hx_c) ? hx_c : cx_q);
		cly_c   = (cy_q < ly_c) ? ly_c : ((cy_q > hy_c) ? hy_c : cy_q);
		case (rec_q.func)
			nrp_pkg::FUNC_POINT: begin
				mx_c = mag33(sub33(rec_q.v0, cx_q));
				my_c = mag33(sub33(rec_q.v1, cy_q));
				ax_c = rec_q.v0;
				ay_c = rec_q.v1;
			end
			nrp_pkg::FUNC_CANDLE: begin
				mx_c = mag33(sub33(cx_q, rec_q.v0));
				if ($signed({1'b0, mx_c}) <= $signed({rec_q.v5[31], rec_q.v5}))
					mx_c = '0;
				if (cy_q >= rec_q.v3 && cy_q <= rec_q.v2)
					my_c = '0;
				else
					my_c = (dl_c < dh_c) ? dl_c : dh_c;
				ax_c = rec_q.v0;
				ay_c = half33(rec_q.v1, rec_q.v4);
			end
			nrp_pkg::FUNC_RECT: begin
				mx_c = mag33(sub33(cx_q, clx_c));
				my_c = mag33(sub33(cy_q, cly_c));
				ax_c = half33(rec_q.v0, rec_q.v2);
				ay_c = half33(rec_q.v1, rec_q.v3);
			end
			default: begin
				valid_c = 1'b0;
			end
		endcase
	end

	logic [31:0] mul_a, mul_b, sat_px;
	logic [64:0] sum_c;
	logic [35:0] sq_rem_c, sq_trial_c;

	always_comb begin
		case (cmd.op)
			nrp_pkg::OP_MX:  begin mul_a = mx_q; mul_b = sx_q; end
			nrp_pkg::OP_MY:  begin mul_a = my_q; mul_b = sy_q; end
			nrp_pkg::OP_SQX: begin mul_a = px_q; mul_b = px_q; end
			nrp_pkg::OP_SQY: begin mul_a = py_q; mul_b = py_q; end
			default:         begin mul_a = md_q; mul_b = md_q; end
		endcase
	end

	assign sat_px     = (prod_q[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod_q[47:16];
	assign sum_c      = {1'b0, sqx_q} + {1'b0, prod_q};
	assign sq_rem_c   = {rem_q, n_q[63:62]};
	assign sq_trial_c = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			sx_q <= nrp_pkg::SCALE_RESET;
			sy_q <= nrp_pkg::SCALE_RESET;
			md_q <= nrp_pkg::MAXD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				nrp_pkg::CFG_CURSOR_X: cx_q <= cfg_data;
				nrp_pkg::CFG_CURSOR_Y: cy_q <= cfg_data;
				nrp_pkg::CFG_SCALE_X:  sx_q <= cfg_data;
				nrp_pkg::CFG_SCALE_Y:  sy_q <= cfg_data;
				nrp_pkg::CFG_MAX_DIST: md_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q       <= 1'b0;
			best_sq_q    <= '0;
			best_item_q  <= '0;
			best_index_q <= '0;
			best_x_q     <= '0;
			best_y_q     <= '0;
		end else if (cmd.op == nrp_pkg::OP_CMP) begin
			if (valid_q && sq_q < prod_q && (!have_q || sq_q < best_sq_q)) begin
				have_q       <= 1'b1;
				best_sq_q    <= sq_q;
				best_item_q  <= rec_q.item_id;
				best_index_q <= rec_q.record_index;
				best_x_q     <= ax_q;
				best_y_q     <= ay_q;
			end
		end else if (cmd.op == nrp_pkg::OP_EMIT) begin
			have_q       <= 1'b0;
			best_sq_q    <= '0;
			best_item_q  <= '0;
			best_index_q <= '0;
			best_x_q     <= '0;
			best_y_q     <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			nrp_pkg::OP_LOAD: rec_q <= rec;
			nrp_pkg::OP_DELTA: begin
				mx_q    <= mx_c;
				my_q    <= my_c;
				ax_q    <= ax_c;
				ay_q    <= ay_c;
				valid_q <= valid_c;
			end
			nrp_pkg::OP_MX: prod_q <= mul_a * mul_b;
			nrp_pkg::OP_MY: begin
				px_q   <= sat_px;
				prod_q <= mul_a * mul_b;
			end
			nrp_pkg::OP_SQX: begin
				py_q   <= sat_px;
				prod_q <= mul_a * mul_b;
			end
			nrp_pkg::OP_SQY: begin
				sqx_q  <= prod_q;
				prod_q <= mul_a * mul_b;
			end
			nrp_pkg::OP_MD: begin
				sq_q   <= sum_c[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_c[63:0];
				prod_q <= mul_a * mul_b;
			end
			nrp_pkg::OP_SQI: begin
				n_q    <= best_sq_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			nrp_pkg::OP_SQS: begin
				n_q <= {n_q[61:0], 2'b00};
				if (sq_rem_c >= sq_trial_c) begin
					rem_q  <= 34'(sq_rem_c - sq_trial_c);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= sq_rem_c[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			nrp_pkg::OP_EMIT: begin
				res_q.hit        <= have_q;
				res_q.best_item  <= best_item_q;
				res_q.best_index <= best_index_q;
				res_q.data_x     <= best_x_q;
				res_q.data_y     <= best_y_q;
				res_q.distance   <= root_q;
			end
			default: ;
		endcase
	end

	assign sts.last_rec = rec_q.last;
	assign res          = res_q;

endmodule

[src/nrp_ctrl.sv]
// nrp_ctrl: sequencer for the picker datapath and the result valid flag.
// Depends on nrp_pkg.
module nrp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  nrp_pkg::dp_sts_t sts,
	output nrp_pkg::dp_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DELTA = 4'd1;
	localparam logic [3:0] ST_MX    = 4'd2;
	localparam logic [3:0] ST_MY    = 4'd3;
	localparam logic [3:0] ST_SQX   = 4'd4;
	localparam logic [3:0] ST_SQY   = 4'd5;
	localparam logic [3:0] ST_MD    = 4'd6;
	localparam logic [3:0] ST_CMP   = 4'd7;
	localparam logic [3:0] ST_SQI   = 4'd8;
	localparam logic [3:0] ST_SQS   = 4'd9;
	localparam logic [3:0] ST_EMIT  = 4'd10;

	logic [3:0] state_q, state_d;
	logic [4:0] cnt_q;
	logic out_valid_q, emit;

	assign emit = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		cmd.op  = nrp_pkg::OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = nrp_pkg::OP_LOAD;
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: begin cmd.op = nrp_pkg::OP_DELTA; state_d = ST_MX;  end
			ST_MX:    begin cmd.op = nrp_pkg::OP_MX;    state_d = ST_MY;  end
			ST_MY:    begin cmd.op = nrp_pkg::OP_MY;    state_d = ST_SQX; end
			ST_SQX:   begin cmd.op = nrp_pkg::OP_SQX;   state_d = ST_SQY; end
			ST_SQY:   begin cmd.op = nrp_pkg::OP_SQY;   state_d = ST_MD;  end
			ST_MD:    begin cmd.op = nrp_pkg::OP_MD;    state_d = ST_CMP; end
			ST_CMP: begin
				cmd.op  = nrp_pkg::OP_CMP;
				state_d = sts.last_rec ? ST_SQI : ST_IDLE;
			end
			ST_SQI: begin cmd.op = nrp_pkg::OP_SQI; state_d = ST_SQS; end
			ST_SQS: begin
				cmd.op = nrp_pkg::OP_SQS;
				if (cnt_q == 5'd31)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit) begin
					cmd.op  = nrp_pkg::OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQS)
				cnt_q <= cnt_q + 5'd1;
			else
				cnt_q <= '0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[src/nearest_record_picker.sv]
// nearest_record_picker: nearest chart record to a cursor over a record scan.
// Each record is accepted in idle and then passes the delta stage, the shared
// multiplier steps and the compare while the input stalls; a record marked
// last then runs the 32-step square root and the result load before its
// result is valid. The result register frees the input side while a result
// waits. Reset clears config to defaults and the best-hit state.
module nearest_record_picker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  nrp_pkg::rec_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output nrp_pkg::res_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	nrp_pkg::dp_cmd_t cmd;
	nrp_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	nrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	nrp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rec       (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.res       (out_data)
	);

endmodule
